// ----- hdl/ppow_pkg.sv -----
`timescale 1ns / 1ps
package ppow_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = 7;
  localparam int EXP_W   = 32;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [5:0]              entry_index;
    logic [5:0]              entry_value;
    logic signed [EXP_W-1:0] exponent;
  } req_t;

  typedef struct packed {
    logic [5:0] result_index;
    logic [5:0] result_value;
    logic       last_entry;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_PRD,
    ST_PWR,
    ST_BIT,
    ST_MRR,
    ST_MRA,
    ST_MW,
    ST_SR1,
    ST_SR2,
    ST_SW,
    ST_ORD,
    ST_OUT
  } state_t;

endpackage

// ----- hdl/ppow_ram.sv -----
`timescale 1ns / 1ps
module ppow_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/permutation_power_unit.sv -----
`timescale 1ns / 1ps
// Channel  | Signals                        | Direction
// req      | req_valid, req_ready, req      | in  (load entry or compute)
// res      | res_valid, res_ready, res      | out (one per position)
// cfg      | cfg_we, cfg_data               | in  (perm_len)
// A load request is taken in the idle state. A compute request writes the identity, then
// the map (its inverse for a negative power), then multiplies and squares over the bits of
// |m|, each step going through the single read port of each map memory, and then offers
// the results in index order, each read from the result store before it is offered.
// Synchronous reset clears control and sets perm_len to 64; the stores are not cleared.
// A stalled result holds; no request is taken until the last result has gone.
module permutation_power_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  ppow_pkg::req_t                    req,
  output logic                              res_valid,
  input  logic                              res_ready,
  output ppow_pkg::res_t                    res,
  input  logic                              cfg_we,
  input  logic [ppow_pkg::LEN_W-1:0]        cfg_data
);
  import ppow_pkg::*;

  state_t              state, state_next;
  logic [ADDR_W-1:0]   x, x_next;
  logic [EXP_W-1:0]    e, e_next;
  logic                sel, sel_next;
  logic                neg, neg_next;
  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    n_act;
  logic                last_x;

  logic              p_we, p_re, r_we, r_re, a_re, b_we;
  logic [ADDR_W-1:0] p_waddr, p_raddr, r_waddr, r_raddr, a_raddr, b_waddr;
  logic [5:0]        p_wdata, r_wdata, b_wdata;
  logic [5:0]        p_rdata, r_rdata, w0_rdata, w1_rdata, a_rdata;
  logic              w0_we, w1_we;
  logic [5:0]        img;

  always_comb begin
    if (len == '0) begin
      n_act = LEN_W'(1);
    end else if (len > LEN_W'(MAX_LEN)) begin
      n_act = LEN_W'(MAX_LEN);
    end else begin
      n_act = len;
    end
  end

  assign last_x  = (x == ADDR_W'(n_act - LEN_W'(1)));
  assign a_rdata = sel ? w1_rdata : w0_rdata;
  // out-of-range image is a fixed point
  assign img     = ({1'b0, p_rdata} < n_act) ? p_rdata : x;

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LEN_W'(MAX_LEN);
    end else if (cfg_we) begin
      len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      x     <= '0;
      e     <= '0;
      sel   <= 1'b0;
      neg   <= 1'b0;
    end else begin
      state <= state_next;
      x     <= x_next;
      e     <= e_next;
      sel   <= sel_next;
      neg   <= neg_next;
    end
  end

  always_comb begin
    state_next = state;
    x_next     = x;
    e_next     = e;
    sel_next   = sel;
    neg_next   = neg;
    req_ready  = 1'b0;
    p_we = 1'b0; p_waddr = req.entry_index; p_wdata = req.entry_value;
    p_re = 1'b0; p_raddr = x;
    r_we = 1'b0; r_waddr = x; r_wdata = x;
    r_re = 1'b0; r_raddr = x;
    a_re = 1'b0; a_raddr = x;
    b_we = 1'b0; b_waddr = x; b_wdata = x;
    w0_we = 1'b0; w1_we = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req.req_type == REQ_LOAD) begin
            p_we = 1'b1;
          end else begin
            neg_next   = req.exponent[EXP_W-1];
            e_next     = req.exponent[EXP_W-1] ? (EXP_W'(0) - EXP_W'(req.exponent))
                                               : EXP_W'(req.exponent);
            x_next     = '0;
            sel_next   = 1'b0;
            state_next = ST_CLR;
          end
        end
      end
      ST_CLR: begin
        // identity into map and accumulator
        w0_we = 1'b1;
        r_we  = 1'b1;
        x_next = last_x ? '0 : x + ADDR_W'(1);
        if (last_x) state_next = ST_PRD;
      end
      ST_PRD: begin
        p_re = 1'b1;
        state_next = ST_PWR;
      end
      ST_PWR: begin
        w0_we = 1'b1;
        b_waddr = neg ? img : x;
        b_wdata = neg ? x : img;
        x_next = last_x ? '0 : x + ADDR_W'(1);
        state_next = last_x ? ST_BIT : ST_PRD;
      end
      ST_BIT: begin
        x_next = '0;
        if (e == '0) begin
          state_next = ST_ORD;
        end else if (e[0]) begin
          state_next = ST_MRR;
        end else begin
          state_next = ST_SR1;
        end
      end
      ST_MRR: begin
        r_re = 1'b1;
        state_next = ST_MRA;
      end
      ST_MRA: begin
        a_re = 1'b1;
        a_raddr = r_rdata;
        state_next = ST_MW;
      end
      ST_MW: begin
        r_we = 1'b1;
        r_wdata = a_rdata;
        x_next = last_x ? '0 : x + ADDR_W'(1);
        if (!last_x) begin
          state_next = ST_MRR;
        end else if ((e >> 1) != '0) begin
          state_next = ST_SR1;
        end else begin
          e_next = '0;
          state_next = ST_BIT;
        end
      end
      ST_SR1: begin
        a_re = 1'b1;
        state_next = ST_SR2;
      end
      ST_SR2: begin
        a_re = 1'b1;
        a_raddr = a_rdata;
        state_next = ST_SW;
      end
      ST_SW: begin
        // square into the other buffer
        b_we = 1'b1;
        b_wdata = a_rdata;
        if (sel) w0_we = 1'b1; else w1_we = 1'b1;
        x_next = last_x ? '0 : x + ADDR_W'(1);
        if (last_x) begin
          sel_next = ~sel;
          e_next = e >> 1;
          state_next = ST_BIT;
        end else begin
          state_next = ST_SR1;
        end
      end
      ST_ORD: begin
        r_re = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (res_ready) begin
          x_next = last_x ? '0 : x + ADDR_W'(1);
          state_next = last_x ? ST_IDLE : ST_ORD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (state == ST_CLR || state == ST_PWR) begin
      w0_we = 1'b1;
    end
    if (b_we == 1'b0 && (state == ST_CLR || state == ST_PWR)) begin
      b_we = 1'b1;
    end
  end

  assign res_valid         = (state == ST_OUT);
  assign res.result_index  = x;
  assign res.result_value  = r_rdata;
  assign res.last_entry    = last_x;

  ppow_ram #(.WIDTH(6), .DEPTH(MAX_LEN)) u_perm (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
  );

  ppow_ram #(.WIDTH(6), .DEPTH(MAX_LEN)) u_work0 (
    .clk(clk), .we(w0_we & b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(a_re & ~sel), .raddr(a_raddr), .rdata(w0_rdata)
  );

  ppow_ram #(.WIDTH(6), .DEPTH(MAX_LEN)) u_work1 (
    .clk(clk), .we(w1_we & b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(a_re & sel), .raddr(a_raddr), .rdata(w1_rdata)
  );

  ppow_ram #(.WIDTH(6), .DEPTH(MAX_LEN)) u_result (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .re(r_re), .raddr(r_raddr), .rdata(r_rdata)
  );

endmodule

// ----- hdl/ppow_checker.sv -----
`timescale 1ns / 1ps
module ppow_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input ppow_pkg::req_t             req,
  input logic                       res_valid,
  input logic                       res_ready,
  input ppow_pkg::res_t             res
);
  import ppow_pkg::*;

  // hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_compute_blocks: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.req_type == REQ_COMPUTE |=> !req_ready)
    else $error("request taken during compute");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !req_ready)
    else $error("request ready while results pending");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res.last_entry |=> !req_ready)
    else $error("result stream ended without last flag");

endmodule

bind permutation_power_unit ppow_checker u_ppow_checker (.*);

// ----- tb/sv/tb_permutation_power_unit.sv -----
`timescale 1ns / 1ps
module tb_permutation_power_unit;
  import ppow_pkg::*;

  localparam int STALL_LIMIT = 200000;
  localparam int SETTLE      = 40;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic res_valid;
  logic res_ready;
  res_t res;
  logic cfg_we;
  logic [LEN_W-1:0] cfg_data;

  permutation_power_unit DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // mirror of the block's loaded entries and length register
  logic [5:0] perm_mirror [MAX_LEN];
  logic [LEN_W-1:0] len_mirror;
  res_t power_queue [$];

  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int n_loads, n_computes, n_results;
  int quiet_cycles;

  function automatic int used_len();
    int n;
    n = len_mirror;
    if (n < 1) n = 1;
    if (n > MAX_LEN) n = MAX_LEN;
    return n;
  endfunction

  // e-fold iterate of a general map, tail and cycle found on the way
  function automatic int iterate_map(input logic [5:0] fmap [MAX_LEN], input int start,
                                     input bit [31:0] e);
    int seen [MAX_LEN];
    int x, k, t, clen;
    bit [31:0] s;
    foreach (seen[i]) seen[i] = -1;
    x = start;
    k = 0;
    while (seen[x] < 0) begin
      if (k == e) return x;
      seen[x] = k;
      x = fmap[x];
      k++;
    end
    t = seen[x];
    clen = k - t;
    s = (e - t) % clen;
    while (s > 0) begin
      x = fmap[x];
      s--;
    end
    return x;
  endfunction

  task automatic predict_power(input logic signed [EXP_W-1:0] m);
    logic [5:0] fmap [MAX_LEN];
    int n, img;
    bit neg;
    bit [31:0] e;
    res_t r;
    n = used_len();
    neg = m[EXP_W-1];
    e = neg ? (32'd0 - m) : m;
    for (int i = 0; i < MAX_LEN; i++) fmap[i] = 6'(i);
    for (int i = 0; i < n; i++) begin
      img = (perm_mirror[i] < n) ? perm_mirror[i] : i;
      if (neg) fmap[img] = 6'(i);
      else fmap[i] = 6'(img);
    end
    for (int i = 0; i < n; i++) begin
      r.result_index = 6'(i);
      r.result_value = 6'(iterate_map(fmap, i, e));
      r.last_entry = (i == n - 1);
      power_queue.push_back(r);
    end
  endtask

  task automatic send_request(input req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    if (item.req_type == REQ_LOAD) begin
      perm_mirror[item.entry_index] = item.entry_value;
      n_loads++;
    end else begin
      predict_power(item.exponent);
      n_computes++;
    end
    @(negedge clk);
  endtask

  task automatic load_entry(input int idx, input int val);
    req_t item;
    item = '0;
    item.req_type = REQ_LOAD;
    item.entry_index = 6'(idx);
    item.entry_value = 6'(val);
    item.exponent = $urandom;
    send_request(item);
  endtask

  task automatic compute(input logic signed [EXP_W-1:0] m);
    req_t item;
    item.req_type = REQ_COMPUTE;
    item.entry_index = 6'($urandom);
    item.entry_value = 6'($urandom);
    item.exponent = m;
    send_request(item);
  endtask

  // drop the request line and let the block go quiet
  task automatic drain();
    req_valid <= 1'b0;
    wait (power_queue.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_length(input int v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= LEN_W'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    len_mirror = LEN_W'(v);
  endtask

  task automatic load_shuffled(input int n, input int rotate_by);
    int perm [MAX_LEN];
    int j, tmp;
    for (int i = 0; i < n; i++) perm[i] = (i + rotate_by) % n;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    for (int i = 0; i < n; i++) load_entry(i, perm[i]);
  endtask

  task automatic test_full_length();
    // every entry is written here, so no later read sees an unwritten one
    for (int i = 0; i < MAX_LEN; i++) load_entry(i, (i + 5) % MAX_LEN);
    compute(0);
    compute(1);
    compute(-1);
    compute(32'sh7fffffff);
    compute(32'sh80000000);
  endtask

  task automatic test_special_cases();
    set_length(6);
    load_entry(0, 3); load_entry(1, 0); load_entry(2, 4);
    load_entry(3, 1); load_entry(4, 2); load_entry(5, 5);
    compute(-32'sd2147483647);
    compute(7);
    // image out of range and stores beyond the length
    load_entry(2, 63);
    load_entry(40, 1);
    compute(3);
    // not a permutation: tails into a cycle, later scatter wins
    load_entry(0, 1); load_entry(1, 1); load_entry(3, 1);
    compute(-2);
    compute(5);
    set_length(0);
    compute(-13);
    set_length(127);
    compute(2);
    set_length(1);
    compute(32'sh80000000);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int items);
    int done, n, k;
    logic signed [EXP_W-1:0] m;
    done = 0;
    while (done < items) begin
      drain();
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      n = ($urandom_range(9) == 0) ? MAX_LEN : $urandom_range(1, 10);
      if ($urandom_range(11) == 0) n = ($urandom_range(1)) ? 0 : $urandom_range(65, 127);
      set_length(n);
      n = used_len();
      load_shuffled(n, $urandom_range(n - 1));
      done += n;
      // corrupt now and then: bad images, far indexes, duplicates
      k = $urandom_range(3);
      if ($urandom_range(2) == 0) begin
        for (int i = 0; i < k; i++) begin
          load_entry($urandom_range(63), $urandom_range(63));
          done++;
        end
      end
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(5))
          0: m = $urandom;
          1: m = EXP_W'(0) - EXP_W'($urandom_range(40));
          default: m = $urandom_range(40);
        endcase
        // mostly keep the long exponents to short lengths
        if (n == MAX_LEN && $urandom_range(3) != 0) m = m % 9;
        compute(m);
        done++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rst) res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && res_ready) begin
      n_results++;
      if (power_queue.size() == 0) begin
        errors++;
        $display("%0t unexpected result %p", $realtime, res);
      end else begin
        want = power_queue.pop_front();
        if (res.result_index !== want.result_index ||
            res.result_value !== want.result_value ||
            res.last_entry !== want.last_entry) begin
          errors++;
          $display("%0t mismatch: expected %p actual %p", $realtime, want, res);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t watchdog: no progress", $realtime);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    res_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    errors = 0;
    n_loads = 0; n_computes = 0; n_results = 0;
    quiet_cycles = 0;
    len_mirror = 64;
    foreach (perm_mirror[i]) perm_mirror[i] = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_full_length();
    test_special_cases();
    test_random_phase(0, 0, 75);
    test_random_phase(53, 0, 75);
    test_random_phase(0, 53, 75);
    test_random_phase(13, 13, 75);

    drain();
    repeat (20) @(posedge clk);
    if (power_queue.size() != 0) begin
      errors++;
      $display("%0t %0d results never arrived", $realtime, power_queue.size());
    end
    $display("Covered %0d loads and %0d power requests (%0d results) over lengths 0..127,",
             n_loads, n_computes, n_results);
    $display("signed exponents to both extremes, broken maps and four idling mixes.");
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ppow_pkg.sv
hdl/ppow_ram.sv
hdl/permutation_power_unit.sv
hdl/ppow_checker.sv
tb/sv/tb_permutation_power_unit.sv
